/* hdl/spf_pkg.sv */
// ----------------------------------------------------------------------------
// spf_pkg: shared constants and types for the smallest period finder
// Sizes of the comparison chain, the byte path and the result field.
// ----------------------------------------------------------------------------
package spf_pkg;

	localparam int MAX_PERIOD = 42;
	localparam int DATA_W     = 8;
	localparam int PERIOD_W   = 6;
	localparam int LEN_W      = $clog2(MAX_PERIOD + 2);
	localparam int TDATA_O_W  = ((PERIOD_W + 7) / 8) * 8;

	typedef logic [DATA_W-1:0]   byte_t;
	typedef logic [PERIOD_W-1:0] period_t;
	typedef logic [LEN_W-1:0]    len_t;

	// broadcast from the input side to every cell
	typedef struct packed {
		logic  accept;
		logic  last;
		byte_t data;
	} cell_ctrl_t;

endpackage

/* hdl/spf_cell.sv */
// ----------------------------------------------------------------------------
// spf_cell: one delay tap and one period flag
// Holds the byte k+1 places back and the flag for period k+1; the tap
// passes to the next cell on every transaction, the armed bit on all but a last one.
// ----------------------------------------------------------------------------
module spf_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spf_pkg::cell_ctrl_t ctrl,
	input  spf_pkg::byte_t     hist_in,
	input  logic               armed_in,
	output spf_pkg::byte_t     hist_out,
	output logic               armed_out,
	output logic               cand
);
	import spf_pkg::*;

	byte_t hist_q;
	logic  armed_q;
	logic  flag_q;
	logic  flag_next;

	// armed means at least k+1 earlier bytes, so the tap is comparable
	assign flag_next = flag_q & ~(armed_q && (hist_q != ctrl.data));
	// period k+1 is below the length exactly when the tap was armed
	assign cand      = flag_next & armed_q;
	assign hist_out  = hist_q;
	assign armed_out = armed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			armed_q <= 1'b0;
			flag_q  <= 1'b1;
		end else if (ctrl.accept) begin
			hist_q <= hist_in;
			if (ctrl.last) begin
				armed_q <= 1'b0;
				flag_q  <= 1'b1;
			end else begin
				armed_q <= armed_in;
				flag_q  <= flag_next;
			end
		end
	end

endmodule

/* hdl/spf_pick.sv */
// ----------------------------------------------------------------------------
// spf_pick: lowest surviving period
// Isolates the lowest set candidate bit and encodes it, or takes the
// capped length when no candidate is left.
// ----------------------------------------------------------------------------
module spf_pick (
	input  logic [spf_pkg::MAX_PERIOD-1:0] cand,
	input  spf_pkg::period_t               fallback,
	output spf_pkg::period_t               period
);
	import spf_pkg::*;

	logic [MAX_PERIOD-1:0] lowest;
	period_t               enc;

	assign lowest = cand & (~cand + 1'b1);

	always_comb begin
		enc = '0;
		for (int k = 0; k < MAX_PERIOD; k++) begin
			if (lowest[k]) begin
				enc = enc | PERIOD_W'(k + 1);
			end
		end
	end

	assign period = (cand == '0) ? fallback : enc;

endmodule

/* hdl/smallest_period_finder.sv */
// ----------------------------------------------------------------------------
// smallest_period_finder: smallest repeating period of a byte run
// A chain of cells compares each byte with the byte p places back for every
// candidate period; on the last byte the lowest surviving period is sent.
//
//  channel  | direction | tdata              | tlast     | tuser
//  s_*      | in        | [7:0] data_byte    | last      | -
//  m_*      | out       | [5:0] period       | -         | -
//
// one byte per cycle while no result is stalled; every cell compares and shifts in the same cycle
// a result passes from its last byte into the candidate register, then into
// the output register after the lowest-bit search
// reset clears the chain, the length count and the valid bits of both pipeline stages
// a stalled result holds the pipeline and drops s_tready
// ----------------------------------------------------------------------------
module smallest_period_finder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [spf_pkg::DATA_W-1:0]   s_tdata,   // [7:0] data_byte
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [spf_pkg::TDATA_O_W-1:0] m_tdata   // [5:0] period, rest zero
);
	import spf_pkg::*;

	cell_ctrl_t            ctrl;
	byte_t                 hist   [MAX_PERIOD+1];
	logic [MAX_PERIOD:0]   armed;
	logic [MAX_PERIOD-1:0] cand;
	len_t                  length_q;
	period_t               fallback;
	logic                  advance;

	logic [MAX_PERIOD-1:0] cand_s1;
	period_t               fallback_s1;
	logic                  valid_s1;
	period_t               pick_period;
	period_t               period_q;
	logic                  out_valid_q;

	assign advance     = !(out_valid_q && !m_tready);
	assign s_tready    = advance;
	assign ctrl.accept = s_tvalid && advance;
	assign ctrl.last   = s_tlast;
	assign ctrl.data   = s_tdata;

	assign hist[0]  = s_tdata;
	assign armed[0] = 1'b1;

	for (genvar k = 0; k < MAX_PERIOD; k++) begin : g_cell
		spf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.hist_in  (hist[k]),
			.armed_in (armed[k]),
			.hist_out (hist[k+1]),
			.armed_out(armed[k+1]),
			.cand     (cand[k])
		);
	end

	// length after this byte, capped at the largest period
	assign fallback = armed[MAX_PERIOD] ? PERIOD_W'(MAX_PERIOD)
	                                    : PERIOD_W'(length_q + 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else if (ctrl.accept) begin
			if (s_tlast) begin
				length_q <= '0;
			end else if (length_q < LEN_W'(MAX_PERIOD + 1)) begin
				length_q <= length_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= ctrl.accept && s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cand_s1     <= cand;
			fallback_s1 <= fallback;
		end
	end

	spf_pick u_pick (
		.cand    (cand_s1),
		.fallback(fallback_s1),
		.period  (pick_period)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			period_q <= pick_period;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_O_W'(period_q);

endmodule
